// ===== design/sbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbs_pkg;

	// Coordinate and time formats.
	localparam int COORD_BITS = 24;
	localparam int TIME_FRAC_BITS = 16;
	// Signed width of the slab numerators and movements.
	localparam int NW = COORD_BITS + 2;
	// Signed width of a saturated slab time (range minus one lsb to one plus one lsb).
	localparam int TW = TIME_FRAC_BITS + 3;
	// Quotient bits resolved by each divider stage.
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = (TIME_FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

	localparam logic signed [TW-1:0] T_ZERO = '0;
	localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< TIME_FRAC_BITS;
	localparam logic signed [TW-1:0] T_SAT = T_ONE + TW'(1);
	localparam logic signed [TW-1:0] T_NEG = '1;

	// Divider lanes.
	localparam int LANE_X_LO = 0;
	localparam int LANE_X_HI = 1;
	localparam int LANE_Y_LO = 2;
	localparam int LANE_Y_HI = 3;
	localparam int LANES = 4;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] box_x;
		logic signed [COORD_BITS-1:0] box_y;
		logic signed [COORD_BITS-1:0] box_width;
		logic signed [COORD_BITS-1:0] box_height;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} query_t;

	typedef struct packed {
		logic                      hit;
		logic [TIME_FRAC_BITS:0]   enter_time;
		logic [TIME_FRAC_BITS:0]   leave_time;
		logic                      bad_input;
	} result_t;

	// How a lane's slab time is settled.
	typedef enum logic [1:0] {
		KIND_DIV,
		KIND_ZERO,
		KIND_NEG,
		KIND_SAT
	} div_kind_t;

	typedef struct packed {
		div_kind_t               kind;
		logic [NW-1:0]           rem;
		logic [NW-1:0]           den;
		logic [TIME_FRAC_BITS:0] quo;
	} lane_t;

	// Per-item flags that travel beside the divider lanes.
	typedef struct packed {
		logic bad;
		logic still_x;
		logic still_y;
		logic inside_x;
		logic inside_y;
	} side_t;

	typedef struct packed {
		side_t              side;
		lane_t [LANES-1:0]  lane;
	} pipe_t;

endpackage
`default_nettype wire

// ===== design/sbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbs_front import sbs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   query_valid,
	input  wire query_t query,
	output logic        pipe_valid,
	output pipe_t       pipe
);

	// Stage one: far edges, movements and near-edge numerators.
	logic                   valid_s1;
	logic signed [NW-1:0]   hi_x_s1, hi_y_s1, lo_num_x_s1, lo_num_y_s1;
	logic signed [NW-1:0]   move_x_s1, move_y_s1, sx_s1, sy_s1, bx_s1, by_s1;
	logic                   bad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_x_s1 <= NW'(query.box_x) + NW'(query.box_width);
			hi_y_s1 <= NW'(query.box_y) + NW'(query.box_height);
			lo_num_x_s1 <= NW'(query.box_x) - NW'(query.start_x);
			lo_num_y_s1 <= NW'(query.box_y) - NW'(query.start_y);
			move_x_s1 <= NW'(query.end_x) - NW'(query.start_x);
			move_y_s1 <= NW'(query.end_y) - NW'(query.start_y);
			sx_s1 <= NW'(query.start_x);
			sy_s1 <= NW'(query.start_y);
			bx_s1 <= NW'(query.box_x);
			by_s1 <= NW'(query.box_y);
			bad_s1 <= (query.box_width <= 0) || (query.box_height <= 0);
		end
	end

	// Stage two: magnitudes, signs and the still-axis containment checks.
	logic                 valid_s2;
	side_t                side_s2;
	lane_t [LANES-1:0]    lane_s2;
	logic signed [NW-1:0] num_c [LANES];
	logic signed [NW-1:0] den_c [LANES];
	lane_t [LANES-1:0]    lane_c;

	always_comb begin
		num_c[LANE_X_LO] = lo_num_x_s1;
		num_c[LANE_X_HI] = hi_x_s1 - sx_s1;
		num_c[LANE_Y_LO] = lo_num_y_s1;
		num_c[LANE_Y_HI] = hi_y_s1 - sy_s1;
		den_c[LANE_X_LO] = move_x_s1;
		den_c[LANE_X_HI] = move_x_s1;
		den_c[LANE_Y_LO] = move_y_s1;
		den_c[LANE_Y_HI] = move_y_s1;
		for (int i = 0; i < LANES; i++) begin
			lane_c[i].rem = num_c[i][NW-1] ? NW'(-num_c[i]) : NW'(num_c[i]);
			lane_c[i].den = den_c[i][NW-1] ? NW'(-den_c[i]) : NW'(den_c[i]);
			lane_c[i].quo = '0;
			if (num_c[i] == '0) begin
				lane_c[i].kind = KIND_ZERO;
			end else if (num_c[i][NW-1] != den_c[i][NW-1]) begin
				lane_c[i].kind = KIND_NEG;
			end else begin
				lane_c[i].kind = KIND_DIV;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_s2 <= lane_c;
			side_s2.bad <= bad_s1;
			side_s2.still_x <= (move_x_s1 == '0);
			side_s2.still_y <= (move_y_s1 == '0);
			side_s2.inside_x <= (sx_s1 >= bx_s1) && (sx_s1 <= hi_x_s1);
			side_s2.inside_y <= (sy_s1 >= by_s1) && (sy_s1 <= hi_y_s1);
		end
	end

	// Stage three: the integer part of each quotient, which is 0, 1 or saturated.
	lane_t [LANES-1:0] lane_w;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_w[i] = lane_s2[i];
			if (lane_s2[i].kind == KIND_DIV) begin
				if ({1'b0, lane_s2[i].rem} >= {lane_s2[i].den, 1'b0}) begin
					lane_w[i].kind = KIND_SAT;
				end else if (lane_s2[i].rem >= lane_s2[i].den) begin
					lane_w[i].rem = lane_s2[i].rem - lane_s2[i].den;
					lane_w[i].quo = (TIME_FRAC_BITS+1)'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid <= 1'b0;
		end else if (adv) begin
			pipe_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe.side <= side_s2;
			pipe.lane <= lane_w;
		end
	end

endmodule
`default_nettype wire

// ===== design/sbs_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbs_div_stage import sbs_pkg::*; #(
	parameter int NSTEP = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  in_valid,
	input  wire pipe_t in_pipe,
	output logic       out_valid,
	output pipe_t      out_pipe
);

	// NSTEP restoring division steps on every lane.
	pipe_t           nxt;
	logic [NW:0]     rem2;

	always_comb begin
		nxt = in_pipe;
		rem2 = '0;
		for (int i = 0; i < LANES; i++) begin
			for (int k = 0; k < NSTEP; k++) begin
				rem2 = {nxt.lane[i].rem, 1'b0};
				if (rem2 >= {1'b0, nxt.lane[i].den}) begin
					nxt.lane[i].rem = NW'(rem2 - {1'b0, nxt.lane[i].den});
					nxt.lane[i].quo = {nxt.lane[i].quo[TIME_FRAC_BITS-1:0], 1'b1};
				end else begin
					nxt.lane[i].rem = NW'(rem2);
					nxt.lane[i].quo = {nxt.lane[i].quo[TIME_FRAC_BITS-1:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pipe <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== design/sbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbs_back import sbs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  pipe_valid,
	input  wire pipe_t pipe,
	output logic       result_valid,
	output result_t    result
);

	// Saturated slab time of one lane.
	function automatic logic signed [TW-1:0] lane_time(input lane_t l);
		logic signed [TW-1:0] t;
		t = T_ZERO;
		unique case (l.kind)
			KIND_ZERO: t = T_ZERO;
			KIND_NEG:  t = T_NEG;
			KIND_SAT:  t = T_SAT;
			KIND_DIV:  t = (TW'(l.quo) > T_SAT) ? T_SAT : TW'(l.quo);
			default:   t = T_ZERO;
		endcase
		return t;
	endfunction

	// Stage one: order the slab times and narrow the interval on x.
	logic signed [TW-1:0] ax, bx, ay, by, fx, lx;
	logic                 valid_s1;
	logic signed [TW-1:0] first_s1, last_s1, ty0_s1, ty1_s1;
	logic                 ok_x_s1, bad_s1, still_y_s1, inside_y_s1;

	always_comb begin
		ax = lane_time(pipe.lane[LANE_X_LO]);
		bx = lane_time(pipe.lane[LANE_X_HI]);
		ay = lane_time(pipe.lane[LANE_Y_LO]);
		by = lane_time(pipe.lane[LANE_Y_HI]);
		fx = (ax < bx) ? ax : bx;
		lx = (ax < bx) ? bx : ax;
		if (fx < T_ZERO) begin
			fx = T_ZERO;
		end
		if (lx > T_ONE) begin
			lx = T_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pipe_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pipe.side.still_x) begin
				first_s1 <= T_ZERO;
				last_s1 <= T_ONE;
				ok_x_s1 <= pipe.side.inside_x;
			end else begin
				first_s1 <= fx;
				last_s1 <= lx;
				ok_x_s1 <= (fx <= lx);
			end
			ty0_s1 <= (ay < by) ? ay : by;
			ty1_s1 <= (ay < by) ? by : ay;
			bad_s1 <= pipe.side.bad;
			still_y_s1 <= pipe.side.still_y;
			inside_y_s1 <= pipe.side.inside_y;
		end
	end

	// Stage two: narrow on y and form the result item.
	logic signed [TW-1:0] fy, ly;
	logic                 hit_c;

	always_comb begin
		fy = (ty0_s1 > first_s1) ? ty0_s1 : first_s1;
		ly = (ty1_s1 < last_s1) ? ty1_s1 : last_s1;
		if (still_y_s1) begin
			fy = first_s1;
			ly = last_s1;
			hit_c = !bad_s1 && ok_x_s1 && inside_y_s1;
		end else begin
			hit_c = !bad_s1 && ok_x_s1 && (fy <= ly);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.hit <= hit_c;
			result.bad_input <= bad_s1;
			result.enter_time <= hit_c ? fy[TIME_FRAC_BITS:0] : '0;
			result.leave_time <= hit_c ? ly[TIME_FRAC_BITS:0] : '0;
		end
	end

endmodule
`default_nettype wire

// ===== design/segment_box_slab_intersect_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Segment against axis-aligned box overlap test, slab method, in two dimensions.
// The query channel (query_valid, query_stall, query) carries one item per
// accepted handshake: a box and a segment in signed Q16.8. The result channel
// (result_valid, result_stall, result) returns one item per query, in order:
// hit, entry and exit fractions in unsigned Q1.16, and a flag for a box of
// non-positive size.
// The pipeline has three set-up stages (edges and movements, magnitudes,
// integer part of the quotients), eight restoring divider stages of two
// quotient bits each on four lanes in parallel, and two stages that order the
// slab times and narrow the interval on x and then y.
// Throughput is one item per cycle while no result is stalled; the sixteen
// fraction bits of the quotients set the depth.
// Reset clears every stage's valid bit, so the pipeline comes up empty.
// When the receiver stalls a waiting result, the whole pipeline holds and
// query_stall rises in the same cycle; nothing is lost or repeated. Stages
// that are empty still advance behind a stalled result only once it is taken.
module segment_box_slab_intersect_unit import sbs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   query_valid,
	output logic        query_stall,
	input  wire query_t query,
	output logic        result_valid,
	input  wire logic   result_stall,
	output result_t     result
);

	// The pipeline moves whenever the output register is free or being taken.
	logic adv;
	assign adv = !(result_valid && result_stall);
	assign query_stall = !adv;

	logic  div_valid [DIV_STAGES+1];
	pipe_t div_pipe [DIV_STAGES+1];

	sbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.query_valid (query_valid),
		.query       (query),
		.pipe_valid  (div_valid[0]),
		.pipe        (div_pipe[0])
	);

	// Divider stages; the last one takes whatever quotient bits remain.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		localparam int LEFT = TIME_FRAC_BITS - g * DIV_STEPS;
		sbs_div_stage #(
			.NSTEP ((LEFT < DIV_STEPS) ? LEFT : DIV_STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (div_valid[g]),
			.in_pipe   (div_pipe[g]),
			.out_valid (div_valid[g+1]),
			.out_pipe  (div_pipe[g+1])
		);
	end

	sbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.pipe_valid   (div_valid[DIV_STAGES]),
		.pipe         (div_pipe[DIV_STAGES]),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== design/sbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbs_checker import sbs_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    query_valid,
	input wire logic    query_stall,
	input wire query_t  query,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// A box of non-positive size never reports a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_input |-> !result.hit)
		else $error("hit reported for a flagged box");

	// On a hit the entry lies no later than the exit.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit |-> result.enter_time <= result.leave_time)
		else $error("entry after exit");

	// A miss carries zero times.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.enter_time == '0 && result.leave_time == '0)
		else $error("miss with non-zero times");

	// A stalled result item stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A stalled query item stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && query_stall |=> query_valid && $stable(query))
		else $error("stalled query changed");

endmodule

bind segment_box_slab_intersect_unit sbs_checker u_sbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.query_valid  (query_valid),
	.query_stall  (query_stall),
	.query        (query),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
